@@ design/lkvt_pkg.sv @@
// Shared widths, request codes and parameter defaults for the key/value table.
package lkvt_pkg;

    localparam int REQ_TYPE_W  = 2;
    localparam int REQ_KEY_W   = 64;
    localparam int REQ_VALUE_W = 32;
    localparam int ENTRIES_W   = 5;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int KEY_BITS_DEF    = 64;
    localparam int VALUE_BITS_DEF  = 32;

    localparam logic [REQ_TYPE_W-1:0] REQ_LOOKUP = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_INSERT = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_DELETE = 2'd2;

endpackage

@@ design/linear_key_value_table_top.sv @@
// Key/value table: dense unsorted entries in two memories, linear search and compaction.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------------
//  req     | in        | req_valid/req_ready  | req_type, req_key, req_value
//  rsp     | out       | rsp_valid/rsp_ready  | key_found, value_out, was_done, entries_now,
//          |           |                      | table_full, table_empty
//
// One request at a time. The search reads one slot per cycle from the key and value
// memories (one registered read port each) until a hit or until every entry is read;
// the execute state then applies the request, a found delete moves each later entry down
// one slot in the shift state, and the done state loads the response register.
// Reset clears the control state and entry count; slots are never read before written.
// A stalled response is held in the output register; the next request is taken meanwhile.
module linear_key_value_table_top #(
    parameter int MAX_ENTRIES = lkvt_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = lkvt_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS  = lkvt_pkg::VALUE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  logic [lkvt_pkg::REQ_TYPE_W-1:0]    req_type,
    input  logic [lkvt_pkg::REQ_KEY_W-1:0]     req_key,
    input  logic [lkvt_pkg::REQ_VALUE_W-1:0]   req_value,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output logic                               key_found,
    output logic [lkvt_pkg::REQ_VALUE_W-1:0]   value_out,
    output logic                               was_done,
    output logic [lkvt_pkg::ENTRIES_W-1:0]     entries_now,
    output logic                               table_full,
    output logic                               table_empty
);
    import lkvt_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int VAL_W = (VALUE_BITS < REQ_VALUE_W) ? VALUE_BITS : REQ_VALUE_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_EXEC   = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    logic [KEY_BITS-1:0] key_mem [MAX_ENTRIES];
    logic [VAL_W-1:0]    val_mem [MAX_ENTRIES];

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       issue_reg, issue_next;
    logic [CNT_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                   pend_reg, pend_next;
    logic                   found_reg, found_next;
    logic                   done_reg, done_next;
    logic                   rsp_valid_reg, rsp_valid_next;

    logic [CNT_W-1:0]       slot_reg, slot_next;
    logic [REQ_TYPE_W-1:0]  op_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [VAL_W-1:0]       val_reg;
    logic [VAL_W-1:0]       res_val_reg, res_val_next;
    logic [KEY_BITS-1:0]    key_rd_reg;
    logic [VAL_W-1:0]       val_rd_reg;

    logic                   out_found_reg;
    logic [VAL_W-1:0]       out_val_reg;
    logic                   out_done_reg;
    logic [CNT_W-1:0]       out_count_reg;

    logic                   accept;
    logic                   load_out;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [KEY_BITS-1:0]    wr_key;
    logic [VAL_W-1:0]       wr_val;
    logic [CNT_W-1:0]       shift_dst;
    logic                   hit;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign hit       = pend_reg && (key_rd_reg == key_reg);
    assign shift_dst = cmp_idx_reg - CNT_ONE;
    assign rd_addr   = issue_reg[IDX_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        cmp_idx_next   = cmp_idx_reg;
        pend_next      = pend_reg;
        found_next     = found_reg;
        done_next      = done_reg;
        slot_next      = slot_reg;
        res_val_next   = res_val_reg;
        rsp_valid_next = rsp_valid_reg;
        load_out       = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = count_reg[IDX_W-1:0];
        wr_key         = key_reg;
        wr_val         = val_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    issue_next   = '0;
                    pend_next    = 1'b0;
                    found_next   = 1'b0;
                    done_next    = 1'b0;
                    res_val_next = '0;
                    state_next   = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (hit)
                begin
                    found_next   = 1'b1;
                    slot_next    = cmp_idx_reg;
                    res_val_next = val_rd_reg;
                    pend_next    = 1'b0;
                    state_next   = S_EXEC;
                end
                else if (issue_reg < count_reg)
                begin
                    rd_en        = 1'b1;
                    pend_next    = 1'b1;
                    cmp_idx_next = issue_reg;
                    issue_next   = issue_reg + CNT_ONE;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                if (op_reg != REQ_LOOKUP)
                begin
                    res_val_next = '0;
                end
                case (op_reg)
                    REQ_INSERT:
                    begin
                        if (!found_reg && (count_reg < CNT_MAX))
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CNT_ONE;
                            done_next  = 1'b1;
                        end
                    end
                    REQ_DELETE:
                    begin
                        if (found_reg)
                        begin
                            done_next  = 1'b1;
                            issue_next = slot_reg + CNT_ONE;
                            pend_next  = 1'b0;
                            state_next = S_SHIFT;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SHIFT:
            begin
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = shift_dst[IDX_W-1:0];
                    wr_key  = key_rd_reg;
                    wr_val  = val_rd_reg;
                end
                if (issue_reg < count_reg)
                begin
                    rd_en        = 1'b1;
                    pend_next    = 1'b1;
                    cmp_idx_next = issue_reg;
                    issue_next   = issue_reg + CNT_ONE;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next = count_reg - CNT_ONE;
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    load_out       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            cmp_idx_reg   <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            done_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            cmp_idx_reg   <= cmp_idx_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            done_reg      <= done_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        slot_reg    <= slot_next;
        res_val_reg <= res_val_next;
        if (accept)
        begin
            op_reg  <= req_type;
            key_reg <= req_key[KEY_BITS-1:0];
            val_reg <= req_value[VAL_W-1:0];
        end
        if (load_out)
        begin
            out_found_reg <= found_reg;
            out_val_reg   <= res_val_reg;
            out_done_reg  <= done_reg;
            out_count_reg <= count_reg;
        end
    end

    // Entry storage: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
        end
        if (rd_en)
        begin
            key_rd_reg <= key_mem[rd_addr];
            val_rd_reg <= val_mem[rd_addr];
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign key_found   = out_found_reg;
    assign value_out   = REQ_VALUE_W'(out_val_reg);
    assign was_done    = out_done_reg;
    assign entries_now = ENTRIES_W'(out_count_reg);
    assign table_full  = (out_count_reg == CNT_MAX);
    assign table_empty = (out_count_reg == '0);

endmodule
